/* sv/ddo_pkg.sv */
// Shared types, constants and the arctangent table for the wheel odometry block.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int TICK_BITS_DEF    = 32;

    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_METRES_PER_TICK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_PER_TICK = 2'd1;

    localparam logic [WORD_W-1:0] MPT_RESET = 32'd1104150;
    localparam logic [WORD_W-1:0] HPT_RESET = 32'd382050;

    // CORDIC datapath: Q2.30 values with headroom, binary-angle z
    localparam int                 CW          = 34;
    localparam int                 ATAN_IDX_W  = 5;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [WORD_W-1:0]  QUARTER_TURN = 32'h4000_0000;

    // shared multiplier
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // distance, step magnitude and accumulator widths
    localparam int DIST_W      = 49;
    localparam int SCALE_SHIFT = 30;
    localparam int MAG_W       = 52;
    localparam int ACC_W       = 48;
    localparam int ACC_SUM_W   = 54;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [WORD_W-1:0] right_ticks;
        logic [WORD_W-1:0] left_ticks;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0]        heading;
    } t_out;

    // CORDIC status and result, held until the next rotation finishes
    typedef struct packed {
        logic              busy;
        logic [WORD_W-1:0] cos_mag;
        logic              cos_neg;
        logic [WORD_W-1:0] sin_mag;
        logic              sin_neg;
    } t_cordic_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIST,
        S_HEAD,
        S_ANG,
        S_WAIT,
        S_XH,
        S_XL,
        S_YH,
        S_YL,
        S_YS,
        S_YA,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROT,
        C_FIN
    } t_cstate;

    typedef enum logic [2:0] {
        M_NONE,
        M_DIST,
        M_HEAD,
        M_XH,
        M_XL,
        M_YH,
        M_YL
    } t_mul_sel;

    // atan(2^-i) in binary-angle units, 2^32 = one turn
    function automatic logic [WORD_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [WORD_W-1:0] v;
        begin
            case (idx)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                5'd24: v = 32'd41;
                5'd25: v = 32'd20;
                5'd26: v = 32'd10;
                5'd27: v = 32'd5;
                5'd28: v = 32'd3;
                5'd29: v = 32'd1;
                5'd30: v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/ddo_mul.sv */
// Shared registered multiplier, 33 x 32 unsigned.
// Depends on ddo_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module ddo_mul (
    input  logic                        i_clk,
    input  logic [ddo_pkg::MUL_A_W-1:0] i_a,
    input  logic [ddo_pkg::MUL_B_W-1:0] i_b,
    output logic [ddo_pkg::MUL_P_W-1:0] o_p
);
    import ddo_pkg::*;

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* sv/ddo_cordic.sv */
// Iterative CORDIC rotation: one micro-rotation per cycle, result as magnitude and sign.
// Depends on ddo_pkg (gain, arctangent table, status struct, state enum).
`timescale 1ns / 1ps
`default_nettype none

module ddo_cordic #(
    parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ddo_pkg::WORD_W-1:0] i_angle,
    output ddo_pkg::t_cordic_stat      o_stat
);
    import ddo_pkg::*;

    localparam int IW = $clog2(STEPS);

    t_cstate r_cstate, n_cstate;

    logic [IW-1:0]        r_i;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic                 r_flip;
    logic [WORD_W-1:0]    r_cos_mag, r_sin_mag;
    logic                 r_cos_neg, r_sin_neg;

    logic [WORD_W-1:0]    rot_q;
    logic                 flip_in;
    logic [WORD_W-1:0]    folded;
    logic signed [CW-1:0] xs, ys, at;
    logic signed [CW-1:0] x_abs, y_abs;
    logic                 last_step;

    // fold into [-1/4, 1/4) turn; adding half a turn is a flip of the top bit
    assign rot_q   = i_angle + QUARTER_TURN;
    assign flip_in = rot_q[WORD_W-1];
    assign folded  = i_angle ^ {flip_in, {(WORD_W-1){1'b0}}};

    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign at = $signed({{(CW-WORD_W){1'b0}}, atan_lut(ATAN_IDX_W'(r_i))});

    assign x_abs     = r_x[CW-1] ? -r_x : r_x;
    assign y_abs     = r_y[CW-1] ? -r_y : r_y;
    assign last_step = (r_i == IW'(STEPS - 1));

    always_comb begin
        n_cstate = r_cstate;
        unique case (r_cstate)
            C_IDLE: begin
                if (i_start) begin
                    n_cstate = C_ROT;
                end
            end
            C_ROT: begin
                if (last_step) begin
                    n_cstate = C_FIN;
                end
            end
            C_FIN: begin
                n_cstate = C_IDLE;
            end
            default: begin
                n_cstate = C_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stat.busy    = (r_cstate != C_IDLE);
        o_stat.cos_mag = r_cos_mag;
        o_stat.cos_neg = r_cos_neg;
        o_stat.sin_mag = r_sin_mag;
        o_stat.sin_neg = r_sin_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cstate <= C_IDLE;
        end else begin
            r_cstate <= n_cstate;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cstate)
            C_IDLE: begin
                if (i_start) begin
                    r_x    <= CORDIC_GAIN;
                    r_y    <= '0;
                    r_z    <= CW'($signed(folded));
                    r_flip <= flip_in;
                    r_i    <= '0;
                end
            end
            C_ROT: begin
                if (!r_z[CW-1]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 1'b1;
            end
            C_FIN: begin
                r_cos_mag <= x_abs[WORD_W-1:0];
                r_sin_mag <= y_abs[WORD_W-1:0];
                r_cos_neg <= r_flip ^ r_x[CW-1];
                r_sin_neg <= r_flip ^ r_y[CW-1];
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* sv/diff_drive_odometry.sv */
// Top level of the differential-drive odometry: sequencer, pose state and output register.
// Depends on ddo_pkg, ddo_mul and ddo_cordic.
//
//   channel | dir | handshake               | word
//   --------+-----+-------------------------+---------------------------------
//   in      | in  | i_in_valid / o_in_ready | t_in: right_ticks, left_ticks
//   out     | out | o_out_valid/ i_out_ready| t_out: pos_x, pos_y, heading
//   cfg     | in  | i_cfg_we (no wait)      | i_cfg_idx, i_cfg_data
//
// A word is taken only while the sequencer is idle, so the next word waits until the
// last result is in the output register. Each word runs through the iterative CORDIC,
// then four passes through the shared multiplier; distance and heading products
// overlap the rotation.
// Synchronous active-low reset clears the pose, previous counts and output valid, and loads the config reset values.
// The sequencer stalls at its last step only while the output register is still full and not being read.
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
    parameter int TICK_BITS    = ddo_pkg::TICK_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ddo_pkg::WORD_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ddo_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ddo_pkg::t_out                 o_out
);
    import ddo_pkg::*;

    localparam int DELTA_W = TICK_BITS + 1;

    t_state r_state, n_state;

    logic [WORD_W-1:0]           r_mpt, r_hpt;
    logic [TICK_BITS-1:0]        r_prev_r, r_prev_l;
    logic signed [TICK_BITS-1:0] r_dr, r_dl;
    logic                        r_neg;
    logic [WORD_W-1:0]           r_diff;
    logic [DIST_W-1:0]           r_dist;
    logic [DIST_W-1:0]           r_ph;
    logic [MAG_W-1:0]            r_mag;
    logic signed [ACC_W-1:0]     r_acc_x, r_acc_y;
    logic [WORD_W-1:0]           r_angle;
    t_out                        r_out;
    logic                        r_ovalid;

    logic                        cordic_start;
    logic                        out_load;
    t_mul_sel                    mul_sel;
    t_cordic_stat                cst;
    logic [MUL_A_W-1:0]          mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic [MUL_P_W-1:0]          mul_p;

    logic [TICK_BITS-1:0]        right_t, left_t;
    logic signed [TICK_BITS-1:0] dr_in, dl_in;
    logic signed [DELTA_W-1:0]   sum_d, diff_d;
    logic                        sum_neg;
    logic [DELTA_W-1:0]          sum_mag;
    logic [DIST_W-1:0]           dist_sat;
    logic [MAG_W-1:0]            mag_new;
    logic                        acc_on_y;
    logic                        step_neg;
    logic signed [ACC_SUM_W-1:0] acc_ext, mag_s, acc_sum;
    logic signed [ACC_W-1:0]     acc_next;

    // tick deltas modulo 2^TICK_BITS, read as signed
    assign right_t = i_in.right_ticks[TICK_BITS-1:0];
    assign left_t  = i_in.left_ticks[TICK_BITS-1:0];
    assign dr_in   = $signed(right_t - r_prev_r);
    assign dl_in   = $signed(left_t - r_prev_l);

    assign sum_d   = DELTA_W'(r_dr) + DELTA_W'(r_dl);
    assign diff_d  = DELTA_W'(r_dr) - DELTA_W'(r_dl);
    assign sum_neg = sum_d[DELTA_W-1];
    assign sum_mag = sum_neg ? DELTA_W'(-sum_d) : DELTA_W'(sum_d);

    // (|sum| * metres_per_tick) / 2, clamped to 2^49 - 1
    assign dist_sat = (|mul_p[MUL_P_W-1:DIST_W+1]) ? {DIST_W{1'b1}}
                                                   : mul_p[DIST_W:1];

    // high partial << 2 plus low partial >> 30
    assign mag_new = MAG_W'({r_ph, 2'b00}) + MAG_W'(mul_p[MUL_P_W-1:SCALE_SHIFT]);

    // one saturating accumulate adder, used for x then y
    assign acc_on_y = (r_state == S_YA);
    assign step_neg = r_neg ^ (acc_on_y ? cst.sin_neg : cst.cos_neg);
    assign acc_ext  = ACC_SUM_W'(acc_on_y ? r_acc_y : r_acc_x);
    assign mag_s    = $signed({{(ACC_SUM_W-MAG_W){1'b0}}, r_mag});
    assign acc_sum  = step_neg ? (acc_ext - mag_s) : (acc_ext + mag_s);

    always_comb begin
        if (acc_sum[ACC_SUM_W-1:ACC_W-1] != {(ACC_SUM_W-ACC_W+1){acc_sum[ACC_SUM_W-1]}}) begin
            acc_next = acc_sum[ACC_SUM_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIST;
                end
            end
            S_DIST: n_state = S_HEAD;
            S_HEAD: n_state = S_ANG;
            S_ANG:  n_state = S_WAIT;
            S_WAIT: begin
                if (!cst.busy) begin
                    n_state = S_XH;
                end
            end
            S_XH: n_state = S_XL;
            S_XL: n_state = S_YH;
            S_YH: n_state = S_YL;
            S_YL: n_state = S_YS;
            S_YS: n_state = S_YA;
            S_YA: n_state = S_DONE;
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        cordic_start = (r_state == S_IDLE) && i_in_valid;
        out_load     = (r_state == S_DONE) && (!r_ovalid || i_out_ready);
        unique case (r_state)
            S_DIST:  mul_sel = M_DIST;
            S_HEAD:  mul_sel = M_HEAD;
            S_XH:    mul_sel = M_XH;
            S_XL:    mul_sel = M_XL;
            S_YH:    mul_sel = M_YH;
            S_YL:    mul_sel = M_YL;
            default: mul_sel = M_NONE;
        endcase
    end

    always_comb begin
        unique case (mul_sel)
            M_DIST: begin
                mul_a = MUL_A_W'(sum_mag);
                mul_b = r_mpt;
            end
            M_HEAD: begin
                mul_a = MUL_A_W'(r_diff);
                mul_b = r_hpt;
            end
            M_XH: begin
                mul_a = MUL_A_W'(r_dist[DIST_W-1:WORD_W]);
                mul_b = cst.cos_mag;
            end
            M_XL: begin
                mul_a = MUL_A_W'(r_dist[WORD_W-1:0]);
                mul_b = cst.cos_mag;
            end
            M_YH: begin
                mul_a = MUL_A_W'(r_dist[DIST_W-1:WORD_W]);
                mul_b = cst.sin_mag;
            end
            M_YL: begin
                mul_a = MUL_A_W'(r_dist[WORD_W-1:0]);
                mul_b = cst.sin_mag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (r_angle),
        .o_stat  (cst)
    );

    // control and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mpt    <= MPT_RESET;
            r_hpt    <= HPT_RESET;
            r_prev_r <= '0;
            r_prev_l <= '0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
            r_angle  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_METRES_PER_TICK:  r_mpt <= i_cfg_data;
                    REG_HEADING_PER_TICK: r_hpt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (cordic_start) begin
                r_prev_r <= right_t;
                r_prev_l <= left_t;
            end
            if (r_state == S_ANG) begin
                r_angle <= r_angle + mul_p[WORD_W-1:0];
            end
            if (r_state == S_YL) begin
                r_acc_x <= acc_next;
            end
            if (r_state == S_YA) begin
                r_acc_y <= acc_next;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_dr <= dr_in;
                    r_dl <= dl_in;
                end
            end
            S_DIST: begin
                r_neg  <= sum_neg;
                r_diff <= WORD_W'(diff_d);
            end
            S_HEAD: r_dist <= dist_sat;
            S_XL:   r_ph   <= mul_p[DIST_W-1:0];
            S_YH:   r_mag  <= mag_new;
            S_YL:   r_ph   <= mul_p[DIST_W-1:0];
            S_YS:   r_mag  <= mag_new;
            default: ;
        endcase
        if (out_load) begin
            r_out.pos_x   <= r_acc_x[ACC_W-1:ACC_W-WORD_W];
            r_out.pos_y   <= r_acc_y[ACC_W-1:ACC_W-WORD_W];
            r_out.heading <= r_angle;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

/* sv/ddo_checker.sv */
// Port-level checks on the odometry top level, attached by bind.
// Depends on ddo_pkg for the output word type.
`timescale 1ns / 1ps
`default_nettype none

module ddo_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ddo_pkg::t_out o_out
);

    // the input does not reopen straight after a word is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready)
        else $error("input reopened too soon after a word was taken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result word dropped or changed while stalled");

    // a fresh result always comes with the sequencer back at idle
    a_rise_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result appeared while sequencer still busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset left block busy or a result pending");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
